// ===== rtl/word_string_length_scanner_macros.svh =====
// Assertion macros shared by the scanner RTL.
// Each macro takes a label, a clock, an active-low reset and a property body or condition.
`ifndef WORD_STRING_LENGTH_SCANNER_MACROS_SVH
`define WORD_STRING_LENGTH_SCANNER_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define WSLS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("scanner assertion failed");

// The condition must never be seen at a clock edge outside reset.
`define WSLS_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("scanner forbidden condition seen");

`else

`define WSLS_ASSERT(label, clk, rst_n, prop)
`define WSLS_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== rtl/wsls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wsls_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned LIMIT_W     = 8;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned BYTES       = 8;
  localparam int unsigned BYTE_IDX_W  = 3;
  localparam int unsigned MAX_WORDS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [WORD_W-1:0] SUB_ONES  = 64'h0101_0101_0101_0101;
  localparam logic [WORD_W-1:0] HIGH_BITS = 64'h8080_8080_8080_8080;
  localparam logic [LEN_W-1:0]  LEN_SAT   = 7'h7F;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    logic                  first;
    logic [LIMIT_W-1:0]    limit;
    logic                  has_zero;
    logic [BYTE_IDX_W-1:0] zero_idx;
  } entry_t;

  // Queue occupancy as seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/wsls_word_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wsls_word_if;
  logic                                valid;
  logic                                ready;
  logic [wsls_pkg::WORD_W-1:0]         string_word;
  logic                                first_word;
  logic [wsls_pkg::LIMIT_W-1:0]        max_length;

  modport source (output valid, output string_word, output first_word,
                  output max_length, input ready);
  modport sink   (input valid, input string_word, input first_word,
                  input max_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/wsls_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wsls_result_if;
  logic                         valid;
  logic                         ready;
  logic [wsls_pkg::LEN_W-1:0]   length;
  logic                         too_long;

  modport source (output valid, output length, output too_long, input ready);
  modport sink   (input valid, input length, input too_long, output ready);
endinterface

`default_nettype wire

// ===== rtl/wsls_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Accepts words and finds the lowest zero byte of each.
module wsls_front (
  wsls_word_if.sink             word_i,
  input  wsls_pkg::q_status_t   q_status_i,
  output logic                  push_o,
  output wsls_pkg::entry_t      entry_o
);

  logic [wsls_pkg::WORD_W-1:0]     flags;
  logic [wsls_pkg::BYTE_IDX_W-1:0] idx;

  // The subtract-and-mask test says whether any byte is zero at all.
  assign flags = (word_i.string_word - wsls_pkg::SUB_ONES) & ~word_i.string_word
                 & wsls_pkg::HIGH_BITS;

  // Scan from the top byte down so that the lowest zero byte wins.
  always_comb begin
    idx = '0;
    for (int i = wsls_pkg::BYTES - 1; i >= 0; i--) begin
      if (word_i.string_word[i*8 +: 8] == 8'h00) begin
        idx = wsls_pkg::BYTE_IDX_W'(i);
      end
    end
  end

  assign word_i.ready = !q_status_i.full;
  assign push_o       = word_i.valid && !q_status_i.full;

  assign entry_o.first    = word_i.first_word;
  assign entry_o.limit    = word_i.max_length;
  assign entry_o.has_zero = |flags;
  assign entry_o.zero_idx = idx;

endmodule

`default_nettype wire

// ===== rtl/wsls_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-entry queue between the front and the back.
module wsls_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  wsls_pkg::entry_t      entry_i,
  input  logic                  pop_i,
  output wsls_pkg::entry_t      entry_o,
  output wsls_pkg::q_status_t   status_o
);

  wsls_pkg::entry_t                 mem_q [wsls_pkg::QUEUE_DEPTH];
  logic [wsls_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [wsls_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [wsls_pkg::QCNT_W-1:0]      cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q + (push_i ? 1'b1 : 1'b0);
    rd_ptr_d = rd_ptr_q + (pop_i ? 1'b1 : 1'b0);
    cnt_d    = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o        = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == wsls_pkg::QCNT_W'(wsls_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// ===== rtl/wsls_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Keeps the per-string state, applies each classified word of an open string and holds the result.
module wsls_back #(
  parameter int unsigned MAX_WORDS = wsls_pkg::MAX_WORDS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  wsls_pkg::entry_t     entry_i,
  output logic                 pop_o,
  wsls_result_if.source        result_o
);

  localparam int unsigned CntW = $clog2(MAX_WORDS + 1);
  localparam int unsigned CmpW = 9;

  logic [wsls_pkg::LEN_W-1:0]   rl_q, rl_base, rl_new;
  logic [CntW-1:0]              ws_q, ws_base, consumed;
  logic [wsls_pkg::LIMIT_W-1:0] lim_q, lim;
  logic                         done_q;
  logic                         active, hit, over, emit;
  logic [wsls_pkg::LEN_W:0]     sum;
  logic [3:0]                   step;
  logic                         out_valid_q;
  logic [wsls_pkg::LEN_W-1:0]   out_len_q;
  logic                         out_long_q;

  assign pop_o = q_valid_i && (!out_valid_q || result_o.ready);

  always_comb begin
    active   = entry_i.first || !done_q;
    rl_base  = entry_i.first ? '0 : rl_q;
    ws_base  = entry_i.first ? '0 : ws_q;
    lim      = entry_i.first ? entry_i.limit : lim_q;
    hit      = entry_i.has_zero;
    step     = hit ? {1'b0, entry_i.zero_idx} : 4'd8;
    sum      = {1'b0, rl_base} + {4'b0000, step};
    rl_new   = sum[wsls_pkg::LEN_W] ? wsls_pkg::LEN_SAT : sum[wsls_pkg::LEN_W-1:0];
    consumed = ws_base + CntW'(1);
    over     = (CmpW'({consumed, 3'b000}) > CmpW'(lim))
               || (consumed >= CntW'(MAX_WORDS));
    emit     = active && (hit || over);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rl_q        <= '0;
      ws_q        <= '0;
      lim_q       <= '0;
      done_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && active) begin
        rl_q   <= rl_new;
        ws_q   <= hit ? ws_base : consumed;
        lim_q  <= lim;
        done_q <= hit || over;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_len_q  <= hit ? rl_new : '0;
      out_long_q <= !hit;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.length   = out_len_q;
  assign result_o.too_long = out_long_q;

endmodule

`default_nettype wire

// ===== rtl/word_string_length_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel    Dir  Payload                                   Handshake
// word_i     in   string_word[63:0], first_word, max_length  valid / ready
// result_o   out  length[6:0], too_long                      valid / ready
//
// One word is taken in every cycle while the two-entry queue has room.
// A result is registered once the word that ends the string has passed the queue;
// the back end applies one queued word per cycle while its result register is empty or being read.
// Reset is asynchronous and active low; it leaves the scanner waiting for a
// word marked as the first of a string, with no clearing pass.
// A stalled result only holds back the back end; the front keeps filling the
// queue until it is full, and then lowers ready.

`include "word_string_length_scanner_macros.svh"

module word_string_length_scanner #(
  parameter int unsigned MAX_WORDS = wsls_pkg::MAX_WORDS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  wsls_word_if.sink       word_i,
  wsls_result_if.source   result_o
);

  // The front classifies each word: whether it holds a zero byte and where.
  logic                  push;
  logic                  pop;
  wsls_pkg::entry_t      front_entry;
  wsls_pkg::entry_t      back_entry;
  wsls_pkg::q_status_t   q_status;

  wsls_front u_front (
    .word_i     (word_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (front_entry)
  );

  // The queue lets the back end stall on the result without stopping input.
  wsls_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (front_entry),
    .pop_i    (pop),
    .entry_o  (back_entry),
    .status_o (q_status)
  );

  // The back end owns the running length, word count and limit of a string.
  wsls_back #(
    .MAX_WORDS (MAX_WORDS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (!q_status.empty),
    .entry_i   (back_entry),
    .pop_o     (pop),
    .result_o  (result_o)
  );

  // The front must never write into a full queue.
  `WSLS_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push && q_status.full)
  // The queue cannot pop when it holds nothing.
  `WSLS_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop && q_status.empty)
  // With an empty result register, queued work is always taken at once.
  `WSLS_ASSERT(a_back_busy, clk_i, rst_ni, (!q_status.empty && !result_o.valid) |-> pop)
  // A too-long result reports no length.
  `WSLS_ASSERT(a_long_zero, clk_i, rst_ni, (result_o.valid && result_o.too_long) |-> (result_o.length == '0))

endmodule

`default_nettype wire
